// ===== sv/pidaw_pkg.sv =====
// ============================================================================
// pidaw_pkg
// Shared types and constants of the PID controller with anti-windup clamp.
// ============================================================================
`default_nettype none

package pidaw_pkg;

    // Fixed widths of the register file and of the state.
    localparam int GAIN_W     = 32;
    localparam int CLAMP_W    = 31;
    localparam int TS_W       = 16;
    localparam int ACC_W      = 48;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Saturation limits: each product term, and the integral accumulator.
    localparam logic [63:0] TERM_LIM = 64'h2000_0000_0000_0000;
    localparam logic [63:0] ACC_MAX  = 64'h0000_7FFF_FFFF_FFFF;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_INTEG_CLAMP   = 3'd3,
        REG_OUT_LOW       = 3'd4,
        REG_OUT_HIGH      = 3'd5,
        REG_DERIV_ON_MEAS = 3'd6
    } cfg_reg_t;

    // Product term that the shared multiplier works on.
    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } term_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  clear_hist;
        logic  calc_inc;
        logic  acc_upd;
        logic  acc_lim;
        logic  div_step;
        logic  mul_lo;
        logic  mul_hi;
        logic  mul_add;
        logic  mul_acc;
        logic  finish;
        term_t term;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_item;
        logic special;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/pidaw_ctrl.sv =====
// ============================================================================
// pidaw_ctrl
// Sequencer of one control step: error, integral, divide, three products.
// ============================================================================
`default_nettype none

module pidaw_ctrl
    import pidaw_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DEC  = 11'b000_0000_0010,
        S_INC  = 11'b000_0000_0100,
        S_ACC  = 11'b000_0000_1000,
        S_LIM  = 11'b000_0001_0000,
        S_DIV  = 11'b000_0010_0000,
        S_MLO  = 11'b000_0100_0000,
        S_MHI  = 11'b000_1000_0000,
        S_MADD = 11'b001_0000_0000,
        S_MACC = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    term_t  term_reg, term_next;

    // State and term registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= TERM_P;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.term   = term_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.clear_hist = stat.clr_item;
                state_next     = stat.special ? S_FIN : S_INC;
            end
            S_INC:
            begin
                cmd.calc_inc = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_upd = 1'b1;
                state_next  = S_LIM;
            end
            S_LIM:
            begin
                cmd.acc_lim = 1'b1;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    term_next  = TERM_P;
                    state_next = S_MLO;
                end
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_MADD;
            end
            S_MADD:
            begin
                cmd.mul_add = 1'b1;
                state_next  = S_MACC;
            end
            S_MACC:
            begin
                cmd.mul_acc = 1'b1;
                if (term_reg == TERM_D)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    term_next  = term_t'(term_reg + 2'd1);
                    state_next = S_MLO;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pidaw_dp.sv =====
// ============================================================================
// pidaw_dp
// Datapath: registers, integral, serial divider, shared multiplier, output.
// ============================================================================
`default_nettype none

module pidaw_dp
    import pidaw_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 16
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [CFG_ADDR_W-1:0]        cfg_addr,
    input  wire  [CFG_DATA_W-1:0]        cfg_data,
    input  wire                          in_kind,
    input  wire  signed [SAMPLE_WIDTH-1:0] in_target,
    input  wire  signed [SAMPLE_WIDTH-1:0] in_measured,
    input  wire  [TS_W-1:0]              in_time_step,
    input  cmd_t                         cmd,
    output stat_t                        stat,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_drive,
    output logic                         out_step_invalid
);

    localparam int S      = SAMPLE_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int EW     = S + 1;
    localparam int DLW    = S + 2;
    localparam int DMW    = S + 1;
    localparam int QW     = DMW + TS_W + F;
    localparam int CW     = $clog2(QW);
    localparam int PW_INC = EW + TS_W;
    localparam int SHL    = (F >= 16) ? F - 16 : 0;
    localparam int SHR    = (F < 16) ? 16 - F : 0;
    localparam int IEW    = PW_INC + SHL;
    localparam int INC_W  = S + 1 + F;
    localparam int ILW    = (CLAMP_W > S + F - 1) ? CLAMP_W : S + F - 1;
    localparam int AW     = ((INC_W > ACC_W) ? INC_W : ACC_W) + 2;
    localparam int CMPW   = ((AW > ILW) ? AW : ILW) + 2;
    localparam int QXW    = (QW > 64) ? QW : 64;
    localparam int DVW    = 62;

    // Configuration registers.
    logic signed [GAIN_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [CLAMP_W-1:0]       integ_clamp_reg;
    logic signed [S-1:0]      out_low_reg, out_high_reg;
    logic                     deriv_on_meas_reg;

    // Item registers.
    logic signed [S-1:0]  tgt_reg, meas_reg;
    logic [TS_W-1:0]      ts_reg;
    logic                 clr_reg, special_reg, invalid_reg;

    // Controller state kept across items.
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [S-1:0]     last_meas_reg;
    logic signed [EW-1:0]    last_err_reg;
    logic                    hist_valid_reg;

    // Per-step working registers.
    logic signed [EW-1:0]  err_reg;
    logic [INC_W-1:0]      inc_mag_reg;
    logic                  inc_neg_reg;
    logic signed [DLW-1:0] delta_reg;
    logic                  dv_en_reg;
    logic [TS_W-1:0]       rem_reg;
    logic [QW-1:0]         quo_reg;
    logic [CW-1:0]         cnt_reg;
    logic [63:0]           mul_reg, lo_reg;
    logic [95:0]           prod_reg;
    logic signed [63:0]    sum_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            integ_clamp_reg   <= '0;
            out_low_reg       <= {1'b1, {(S-1){1'b0}}};
            out_high_reg      <= {1'b0, {(S-1){1'b1}}};
            deriv_on_meas_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PROP_GAIN:     prop_gain_reg     <= signed'(cfg_data[GAIN_W-1:0]);
                REG_INTEG_GAIN:    integ_gain_reg    <= signed'(cfg_data[GAIN_W-1:0]);
                REG_DERIV_GAIN:    deriv_gain_reg    <= signed'(cfg_data[GAIN_W-1:0]);
                REG_INTEG_CLAMP:   integ_clamp_reg   <= cfg_data[CLAMP_W-1:0];
                REG_OUT_LOW:       out_low_reg       <= signed'(cfg_data[S-1:0]);
                REG_OUT_HIGH:      out_high_reg      <= signed'(cfg_data[S-1:0]);
                REG_DERIV_ON_MEAS: deriv_on_meas_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Error, integral increment and derivative delta.
    logic signed [EW-1:0]  err_c;
    logic [EW-1:0]         err_mag_c;
    logic [PW_INC-1:0]     inc_prod;
    logic [INC_W-1:0]      inc_mag_c;
    logic signed [DLW-1:0] delta_c;

    always_comb
    begin
        err_c     = EW'(tgt_reg) - EW'(meas_reg);
        err_mag_c = err_c[EW-1] ? unsigned'(-err_c) : unsigned'(err_c);
        inc_prod  = PW_INC'(err_mag_c) * PW_INC'(ts_reg);
        inc_mag_c = INC_W'((IEW'(inc_prod) << SHL) >> SHR);
        if (deriv_on_meas_reg)
            delta_c = DLW'(meas_reg) - DLW'(last_meas_reg);
        else
            delta_c = DLW'(err_c) - DLW'(last_err_reg);
    end

    // Accumulator update with saturation.
    logic signed [AW-1:0] acc_ext, inc_ext, acc_sum;
    logic signed [AW-1:0] acc_max_w;
    logic signed [ACC_W-1:0] acc_sat;

    always_comb
    begin
        acc_ext   = AW'(acc_reg);
        inc_ext   = signed'(AW'(inc_mag_reg));
        acc_max_w = signed'(AW'(ACC_MAX));
        acc_sum   = acc_ext + (inc_neg_reg ? -inc_ext : inc_ext);
        if (acc_sum > acc_max_w)
            acc_sat = ACC_W'(acc_max_w);
        else if (acc_sum < -acc_max_w)
            acc_sat = ACC_W'(-acc_max_w);
        else
            acc_sat = ACC_W'(acc_sum);
    end

    // Integral limit: the configured one, or half the output span.
    logic signed [S:0]       span_diff;
    logic                    clamp_on;
    logic [ILW-1:0]          ilim;
    logic signed [CMPW-1:0]  acc_cmp, lim_cmp;
    logic signed [ACC_W-1:0] acc_lim_c;

    always_comb
    begin
        span_diff = (S+1)'(out_high_reg) - (S+1)'(out_low_reg);
        clamp_on  = out_high_reg > out_low_reg;
        if (integ_clamp_reg != '0)
            ilim = ILW'(integ_clamp_reg);
        else if (clamp_on)
            ilim = ILW'(span_diff[S-1:0]) << (F - 1);
        else
            ilim = '0;
        acc_cmp = CMPW'(acc_reg);
        lim_cmp = signed'(CMPW'(ilim));
        acc_lim_c = acc_reg;
        if (ilim != '0)
        begin
            if (acc_cmp > lim_cmp)
                acc_lim_c = ACC_W'(lim_cmp);
            else if (acc_cmp < -lim_cmp)
                acc_lim_c = ACC_W'(-lim_cmp);
        end
    end

    // Restoring divider step: one quotient bit per cycle.
    logic [DMW-1:0]  dmag_c;
    logic [TS_W:0]   rem_sh;
    logic            rem_ge;
    logic [TS_W:0]   rem_sub;

    always_comb
    begin
        dmag_c  = delta_reg[DLW-1] ? DMW'(unsigned'(-delta_reg))
                                   : DMW'(unsigned'(delta_reg));
        rem_sh  = {rem_reg, quo_reg[QW-1]};
        rem_ge  = rem_sh >= {1'b0, ts_reg};
        rem_sub = rem_sh - {1'b0, ts_reg};
    end

    // Derivative magnitude, saturated.
    logic [QXW-1:0] q_ext;
    logic [DVW-1:0] dv_mag;

    always_comb
    begin
        q_ext  = QXW'(quo_reg);
        dv_mag = (q_ext > QXW'(TERM_LIM)) ? DVW'(TERM_LIM) : DVW'(q_ext);
    end

    // Operand selection for the shared multiplier.
    logic signed [GAIN_W-1:0] g_sel;
    logic [GAIN_W-1:0]        g_mag;
    logic [63:0]              b_mag;
    logic                     b_neg;
    logic                     t_neg;
    logic [EW-1:0]            err_mag_r;
    logic [ACC_W-1:0]         acc_mag;

    always_comb
    begin
        err_mag_r = err_reg[EW-1] ? unsigned'(-err_reg) : unsigned'(err_reg);
        acc_mag   = acc_reg[ACC_W-1] ? unsigned'(-acc_reg) : unsigned'(acc_reg);
        case (cmd.term)
            TERM_P:
            begin
                g_sel = prop_gain_reg;
                b_mag = 64'(err_mag_r);
                b_neg = err_reg[EW-1];
            end
            TERM_I:
            begin
                g_sel = integ_gain_reg;
                b_mag = 64'(acc_mag);
                b_neg = acc_reg[ACC_W-1];
            end
            default:
            begin
                g_sel = deriv_gain_reg;
                b_mag = 64'(dv_mag);
                b_neg = delta_reg[DLW-1] ^ deriv_on_meas_reg;
            end
        endcase
        g_mag = g_sel[GAIN_W-1] ? unsigned'(-g_sel) : unsigned'(g_sel);
        t_neg = g_sel[GAIN_W-1] ^ b_neg;
    end

    // Term scaling and saturation.
    logic [95:0] t_shift;
    logic [63:0] t_sat;

    always_comb
    begin
        t_shift = prod_reg >> F;
        t_sat   = (t_shift > 96'(TERM_LIM)) ? TERM_LIM : t_shift[63:0];
    end

    // Final scaling to a sample and output clamp.
    logic [63:0]        sum_mag, y_mag;
    logic signed [63:0] y_c, y_lo, y_hi, y_cl;

    always_comb
    begin
        sum_mag = sum_reg[63] ? unsigned'(-sum_reg) : unsigned'(sum_reg);
        y_mag   = sum_mag >> F;
        y_c     = sum_reg[63] ? -signed'(y_mag) : signed'(y_mag);
        if (clamp_on)
        begin
            y_lo = 64'(out_low_reg);
            y_hi = 64'(out_high_reg);
        end
        else
        begin
            y_lo = -(64'sd1 <<< (S - 1));
            y_hi = (64'sd1 <<< (S - 1)) - 64'sd1;
        end
        if (y_c < y_lo)
            y_cl = y_lo;
        else if (y_c > y_hi)
            y_cl = y_hi;
        else
            y_cl = y_c;
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tgt_reg     <= in_target;
            meas_reg    <= in_measured;
            ts_reg      <= in_time_step;
            clr_reg     <= in_kind;
            special_reg <= in_kind | (in_time_step == '0);
            invalid_reg <= ~in_kind & (in_time_step == '0);
        end
    end

    // History and integral state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            last_meas_reg  <= '0;
            last_err_reg   <= '0;
            hist_valid_reg <= 1'b0;
        end
        else if (cmd.clear_hist)
        begin
            acc_reg        <= '0;
            last_meas_reg  <= '0;
            last_err_reg   <= '0;
            hist_valid_reg <= 1'b0;
        end
        else if (cmd.acc_upd)
        begin
            acc_reg <= acc_sat;
        end
        else if (cmd.acc_lim)
        begin
            acc_reg        <= acc_lim_c;
            last_meas_reg  <= meas_reg;
            last_err_reg   <= err_reg;
            hist_valid_reg <= 1'b1;
        end
    end

    // Working registers of one step.
    always_ff @(posedge clk)
    begin
        if (cmd.calc_inc)
        begin
            err_reg     <= err_c;
            inc_mag_reg <= inc_mag_c;
            inc_neg_reg <= err_c[EW-1];
            delta_reg   <= delta_c;
            dv_en_reg   <= hist_valid_reg;
        end
        if (cmd.acc_upd)
        begin
            quo_reg <= dv_en_reg ? (QW'(dmag_c) << (TS_W + F)) : '0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[QW-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[TS_W-1:0] : rem_sh[TS_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.acc_lim)
            sum_reg <= '0;
        if (cmd.mul_lo)
            mul_reg <= 64'(g_mag) * 64'(b_mag[31:0]);
        if (cmd.mul_hi)
        begin
            lo_reg  <= mul_reg;
            mul_reg <= 64'(g_mag) * 64'(b_mag[63:32]);
        end
        if (cmd.mul_add)
            prod_reg <= 96'(lo_reg) + (96'(mul_reg) << 32);
        if (cmd.mul_acc)
            sum_reg <= t_neg ? sum_reg - signed'(t_sat) : sum_reg + signed'(t_sat);
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.finish)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_drive        <= special_reg ? '0 : y_cl[S-1:0];
            out_step_invalid <= invalid_reg;
        end
    end

    assign stat.clr_item = clr_reg;
    assign stat.special  = special_reg;
    assign stat.div_done = (cnt_reg == CW'(QW - 1));
    assign stat.out_free = ~out_valid | out_ready;

endmodule

`default_nettype wire

// ===== sv/pid_controller_antiwindup.sv =====
// ============================================================================
// pid_controller_antiwindup
// Fixed-point PID controller with integral clamp and output clamp.
// ============================================================================
// One item at a time: the next item is accepted only after the step finishes.
// A control step passes the accepting state, four setup states (decode,
// increment, accumulate, limit), the serial divider that forms the derivative
// one quotient bit per cycle (SAMPLE_WIDTH + FRAC_BITS + 17 bits), the three
// gain products on the shared 32x32 multiplier, and the output state.
// Clear items and items with a zero time step go from decode straight to the
// output state. The result waits in an output register; the step finishes
// once that register is free.
// Gains are signed Q(32-FRAC_BITS).FRAC_BITS, the time step is unsigned Q0.16 seconds.
`default_nettype none

module pid_controller_antiwindup
    import pidaw_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 16
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire  [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [CFG_DATA_W-1:0]   cfg_data,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    // tdata: target, measured, time_step
    input  wire  [((2*SAMPLE_WIDTH+TS_W+7)/8)*8-1:0] s_tdata,
    // tuser: kind
    input  wire  [0:0]              s_tuser,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    // tdata: drive
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
    // tuser: step_invalid
    output logic [0:0]              m_tuser
);

    localparam int S     = SAMPLE_WIDTH;
    localparam int OUT_W = ((S + 7) / 8) * 8;

    cmd_t  cmd;
    stat_t stat;
    logic signed [S-1:0] drive;

    pidaw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pidaw_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data),
        .in_kind          (s_tuser[0]),
        .in_target        (signed'(s_tdata[S-1:0])),
        .in_measured      (signed'(s_tdata[2*S-1:S])),
        .in_time_step     (s_tdata[2*S+TS_W-1:2*S]),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_drive        (drive),
        .out_step_invalid (m_tuser[0])
    );

    // Pad the drive sample to whole bytes.
    assign m_tdata = OUT_W'(unsigned'(drive));

endmodule

`default_nettype wire

// ===== sv/pidaw_checker.sv =====
// ============================================================================
// pidaw_checker
// Port-level checks of the PID controller, attached by bind.
// ============================================================================
`default_nettype none

module pidaw_checker #(
    parameter int SAMPLE_WIDTH = 16
)
(
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  s_tvalid,
    input wire                                  s_tready,
    input wire                                  m_tvalid,
    input wire                                  m_tready,
    input wire [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,
    input wire [0:0]                            m_tuser
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // An invalid time step always reports a zero drive.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("invalid step with nonzero drive");

    // Items are worked one at a time: no acceptance right after one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // When no result is pending, none shows up right after an item is accepted.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind pid_controller_antiwindup pidaw_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_pidaw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the fixed-point PID controller with anti-windup clamp.
// ----------------------------------------------------------------------------
// Control steps and clear items are sent on the input stream with random gaps.
// A predictor written from the fixed-point behavior computes the expected
// drive value and flag for every accepted item. A checker compares each
// result, in order, with the oldest expectation. Gains, clamps and the
// derivative mode are rewritten between phases while the block is idle.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import pidaw_pkg::*;

    localparam int FB = 16;
    localparam logic [63:0] LIM_T = 64'h2000_0000_0000_0000;
    localparam longint ACC_LIM = (longint'(1) <<< 47) - 1;
    localparam int KIND_STEP  = 0;
    localparam int KIND_CLEAR = 1;
    localparam int WATCHDOG_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    // Predictor state and register copies.
    longint kp, ki, kd, iclamp, olo, ohi;
    bit     d_on_meas;
    longint integ, hist_meas, hist_err;
    bit     hist_ok;

    typedef struct {
        logic [15:0] drive;
        logic        invalid;
    } pid_result_t;
    pid_result_t expected_q[$];

    int  mismatches = 0;
    bit  quiet_tx = 1'b0;     // no sender gaps
    bit  quiet_rx = 1'b0;     // no receiver stalls
    bit  rx_hold = 1'b0;      // long receiver hold-off
    int  idle_cycles = 0;

    pid_controller_antiwindup u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_of(logic [63:0] m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Gain times value, scaled down by the fraction bits and saturated.
    function automatic longint gain_product(longint g, longint b);
        logic [63:0] ua, ub, bh, bl, r;
        bit neg;
        neg = (g < 0) != (b < 0);
        ua = magnitude(g);
        ub = magnitude(b);
        bh = ub >> FB;
        bl = ub & ((64'd1 << FB) - 1);
        if (bh != 0 && ua > LIM_T / bh)
            r = LIM_T;
        else
        begin
            r = ua * bh + ((ua * bl) >> FB);
            if (r > LIM_T)
                r = LIM_T;
        end
        return signed_of(r, neg);
    endfunction

    // Rate of change: delta over the time step, in Q.FB per second.
    function automatic longint rate_of(longint delta, logic [63:0] ts);
        logic [63:0] d, q1, r1, fr, r;
        d = magnitude(delta);
        q1 = (d << 16) / ts;
        r1 = (d << 16) % ts;
        fr = (r1 << FB) / ts;
        if (q1 > (LIM_T >> FB))
            r = LIM_T;
        else
        begin
            r = (q1 << FB) + fr;
            if (r > LIM_T)
                r = LIM_T;
        end
        return signed_of(r, delta < 0);
    endfunction

    function automatic void clear_state();
        integ = 0;
        hist_meas = 0;
        hist_err = 0;
        hist_ok = 1'b0;
    endfunction

    // Computes the result of one item and advances the controller state.
    function automatic pid_result_t pid_predict(bit kind, logic [15:0] tgt_b,
                                                logic [15:0] meas_b, logic [15:0] ts_b);
        pid_result_t res;
        longint tgt, meas, err, ilim, dv, sum, y;
        bit clamp_on;
        res.drive = '0;
        res.invalid = 1'b0;
        clamp_on = ohi > olo;
        if (kind)
        begin
            clear_state();
            return res;
        end
        if (ts_b == 0)
        begin
            res.invalid = 1'b1;
            return res;
        end
        tgt = longint'($signed(tgt_b));
        meas = longint'($signed(meas_b));
        err = tgt - meas;
        integ += signed_of(magnitude(err) * 64'(ts_b), err < 0);
        if (integ > ACC_LIM)
            integ = ACC_LIM;
        if (integ < -ACC_LIM)
            integ = -ACC_LIM;
        ilim = iclamp;
        if (ilim == 0)
            ilim = clamp_on ? ((ohi - olo) <<< (FB - 1)) : 0;
        if (ilim > 0)
        begin
            if (integ > ilim)
                integ = ilim;
            if (integ < -ilim)
                integ = -ilim;
        end
        dv = 0;
        if (hist_ok)
            dv = rate_of(d_on_meas ? meas - hist_meas : err - hist_err, 64'(ts_b));
        hist_meas = meas;
        hist_err = err;
        hist_ok = 1'b1;
        sum = gain_product(kp, err) + gain_product(ki, integ);
        if (d_on_meas)
            sum -= gain_product(kd, dv);
        else
            sum += gain_product(kd, dv);
        y = signed_of(magnitude(sum) >> FB, sum < 0);
        if (clamp_on)
        begin
            if (y < olo)
                y = olo;
            if (y > ohi)
                y = ohi;
        end
        else
        begin
            if (y < -32768)
                y = -32768;
            if (y > 32767)
                y = 32767;
        end
        res.drive = y[15:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Writes one register of the block and of the predictor.
    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PROP_GAIN:     kp = longint'($signed(val));
            REG_INTEG_GAIN:    ki = longint'($signed(val));
            REG_DERIV_GAIN:    kd = longint'($signed(val));
            REG_INTEG_CLAMP:   iclamp = longint'(val[30:0]);
            REG_OUT_LOW:       olo = longint'($signed(val[15:0]));
            REG_OUT_HIGH:      ohi = longint'($signed(val[15:0]));
            REG_DERIV_ON_MEAS: d_on_meas = val[0];
            default: ;
        endcase
    endtask

    task automatic write_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_INTEG_GAIN, i);
        write_reg(REG_DERIV_GAIN, d);
    endtask

    task automatic write_limits(logic [31:0] clamp, logic [15:0] lo, logic [15:0] hi,
                                bit on_meas);
        write_reg(REG_INTEG_CLAMP, clamp);
        write_reg(REG_OUT_LOW, 32'($signed(lo)));
        write_reg(REG_OUT_HIGH, 32'($signed(hi)));
        write_reg(REG_DERIV_ON_MEAS, 32'(on_meas));
    endtask

    // Sends one item; the expectation is queued at acceptance. The block never
    // accepts on the edge right after an acceptance, so each item starts on a
    // fresh edge.
    task automatic send_item(bit kind, logic [15:0] tgt, logic [15:0] meas,
                             logic [15:0] ts);
        @(posedge clk);
        while (!quiet_tx && $urandom_range(99) < 32)
            @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {ts, meas, tgt};
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(pid_predict(kind, tgt, meas, ts));
        s_tvalid <= 1'b0;
    endtask

    // Waits until every result has come, then covers the block's latency.
    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_ts();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1;
            3: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // Directed items: extremes, clear, zero time step, both derivative modes.
    task automatic test_directed();
        write_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_0100);
        write_limits(32'd0, 16'hFF00, 16'h0100, 1'b1);
        send_item(KIND_STEP, 16'd100, 16'd0, 16'h0100);
        send_item(KIND_STEP, 16'd100, 16'd50, 16'h0100);
        send_item(KIND_STEP, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_item(KIND_STEP, 16'h8000, 16'h7FFF, 16'd1);
        send_item(KIND_STEP, 16'd5, 16'd3, 16'd0);
        send_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(KIND_STEP, 16'h8000, 16'h7FFF, 16'd1);
        drain();
        write_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        write_limits(32'h7FFF_FFFF, 16'h0010, 16'h0010, 1'b0);
        send_item(KIND_STEP, 16'h7FFF, 16'h8000, 16'd1);
        send_item(KIND_STEP, 16'h8000, 16'h7FFF, 16'd1);
        send_item(KIND_STEP, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(KIND_STEP, 16'h1234, 16'h4321, 16'h0000);
        drain();
        write_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        write_limits(32'd1, 16'h8000, 16'h7FFF, 1'b1);
        send_item(KIND_STEP, 16'h7FFF, 16'h8000, 16'd1);
        send_item(KIND_STEP, 16'h8000, 16'h7FFF, 16'd1);
        send_item(KIND_CLEAR, 16'd0, 16'd0, 16'd0);
        send_item(KIND_STEP, 16'h0001, 16'h0000, 16'h8000);
        drain();
    endtask

    // Random phases with mostly well-behaved gains and occasional extremes.
    task automatic test_random(int phases, int per_phase);
        logic [15:0] lo, hi;
        for (int p = 0; p < phases; p++)
        begin
            if ($urandom_range(2) == 0)
                write_gains(rand_gain(), rand_gain(), rand_gain());
            else
                write_gains(32'($urandom_range(1 << 18)), 32'($urandom_range(1 << 14)),
                            32'($urandom_range(1 << 10)));
            lo = 16'($signed($urandom_range(4000)) - 4000);
            hi = 16'($urandom_range(4000));
            if ($urandom_range(3) == 0)
            begin
                lo = 16'($urandom);
                hi = 16'($urandom);
            end
            write_limits($urandom_range(3) == 0 ? 32'd0 : ($urandom & 32'h7FFF_FFFF) >> $urandom_range(30),
                         lo, hi, $urandom_range(1));
            quiet_tx = (p == 1);
            quiet_rx = (p == 1);
            for (int n = 0; n < per_phase; n++)
                send_item($urandom_range(19) == 0, rand_sample(), rand_sample(), rand_ts());
            drain();
            quiet_tx = 1'b0;
            quiet_rx = 1'b0;
        end
    endtask

    // Receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                rx_hold = 1'b0;
            end
            for (int n = 0; n < 10; n++)
                send_item(KIND_STEP, rand_sample(), rand_sample(), rand_ts());
        join
        drain();
    endtask

    // Receiver: random stalls, or a held-off stretch.
    always @(posedge clk)
        m_tready <= !rx_hold && (quiet_rx || $urandom_range(99) >= 32);

    // Result checker.
    always @(posedge clk)
    begin
        pid_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", 32'(m_tdata), 32'd0);
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata !== want.drive)
                    report_mismatch("drive", 32'(m_tdata), 32'(want.drive));
                if (m_tuser[0] !== want.invalid)
                    report_mismatch("step_invalid", 32'(m_tuser), 32'(want.invalid));
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        kp = 0;
        ki = 0;
        kd = 0;
        iclamp = 0;
        olo = -32768;
        ohi = 32767;
        d_on_meas = 1'b1;
        clear_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(20, 50);
        drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
